// File: rtl/core/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define DSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion checked during reset too
`define DSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dsd_pkg.sv
// package: types, codes and defaults of the distinguishability table block
package dsd_pkg;

  localparam int MaxStatesDef  = 64;
  localparam int MaxSymbolsDef = 16;

  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] CFG_NUM_STATES  = 2'd0;
  localparam logic [1:0] CFG_NUM_SYMBOLS = 2'd1;

  localparam int EntryW = 7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] source_state;
    logic [3:0] symbol_index;
    logic [5:0] target_state;
  } dsd_in_t;

  typedef struct packed {
    logic [5:0]  row_index;
    logic [63:0] row_bits;
    logic        last_row;
  } dsd_out_t;

  typedef struct packed {
    logic accept;
    logic sweep_wr;
    logic init_wr;
    logic i_rst;
    logic p_set1;
    logic p_inc;
    logic rowp_rd;
    logic rowp_ld;
    logic q_inc;
    logic s_rst;
    logic s_inc;
    logic eval;
    logic wr_p;
    logic wr_q;
    logic chg_clr;
    logic em_rd;
    logic em_out;
  } dsd_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic i_last;
    logic n_one;
    logic p_last;
    logic q_eq_p;
    logic rowp_q;
    logic s_last;
    logic hit;
    logic changed;
  } dsd_sts_t;

endpackage

// File: rtl/core/dsd_ram.sv
// generic single write port ram with registered read
module dsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: rtl/core/dsd_ctrl.sv
// controller: sequences load, clearing sweep, table filling and row output
module dsd_ctrl
  import dsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] opcode,
  input  dsd_sts_t   sts,
  output dsd_cmd_t   cmd,
  output logic       busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_ROWRD = 4'd3;
  localparam logic [3:0] S_ROWWT = 4'd4;
  localparam logic [3:0] S_PAIR  = 4'd5;
  localparam logic [3:0] S_TRD   = 4'd6;
  localparam logic [3:0] S_TWT   = 4'd7;
  localparam logic [3:0] S_MCHK  = 4'd8;
  localparam logic [3:0] S_WRP   = 4'd9;
  localparam logic [3:0] S_WRQ   = 4'd10;
  localparam logic [3:0] S_EMRD  = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (opcode)
            OP_RUN: begin
              cmd.i_rst = 1'b1;
              state_nxt = S_INIT;
            end
            OP_CLEAR: state_nxt = S_SWEEP;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.i_last) begin
          if (sts.n_one) begin
            cmd.i_rst = 1'b1;
            state_nxt = S_EMRD;
          end else begin
            cmd.p_set1  = 1'b1;
            cmd.chg_clr = 1'b1;
            state_nxt   = S_ROWRD;
          end
        end
      end
      S_ROWRD: begin
        cmd.rowp_rd = 1'b1;
        state_nxt   = S_ROWWT;
      end
      S_ROWWT: begin
        cmd.rowp_ld = 1'b1;
        state_nxt   = S_PAIR;
      end
      S_PAIR: begin
        priority if (sts.q_eq_p) begin
          if (sts.p_last) begin
            if (sts.changed) begin
              cmd.chg_clr = 1'b1;
              cmd.p_set1  = 1'b1;
              state_nxt   = S_ROWRD;
            end else begin
              cmd.i_rst = 1'b1;
              state_nxt = S_EMRD;
            end
          end else begin
            cmd.p_inc = 1'b1;
            state_nxt = S_ROWRD;
          end
        end else if (sts.rowp_q) begin
          cmd.q_inc = 1'b1;
        end else begin
          cmd.s_rst = 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_TRD: state_nxt = S_TWT;
      S_TWT: begin
        cmd.eval  = 1'b1;
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        priority if (sts.hit) begin
          state_nxt = S_WRP;
        end else if (sts.s_last) begin
          cmd.q_inc = 1'b1;
          state_nxt = S_PAIR;
        end else begin
          cmd.s_inc = 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_WRP: begin
        cmd.wr_p  = 1'b1;
        state_nxt = S_WRQ;
      end
      S_WRQ: begin
        cmd.wr_q  = 1'b1;
        cmd.q_inc = 1'b1;
        state_nxt = S_PAIR;
      end
      S_EMRD: begin
        cmd.em_rd = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.em_out = 1'b1;
        state_nxt  = sts.i_last ? S_IDLE : S_EMRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/dsd_dp.sv
// datapath: automaton store, distinguishability matrix, counters and output
module dsd_dp
  import dsd_pkg::*;
#(
  parameter int MAX_STATES  = MaxStatesDef,
  parameter int MAX_SYMBOLS = MaxSymbolsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dsd_cmd_t   cmd,
  output dsd_sts_t   sts,
  input  dsd_in_t    in_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  output logic       out_strobe,
  output dsd_out_t   out_item
);

  localparam int SW    = $clog2(MAX_STATES);
  localparam int NW    = $clog2(MAX_STATES + 1);
  localparam int YW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int YNW   = $clog2(MAX_SYMBOLS + 1);
  localparam int TDEP  = MAX_STATES * MAX_SYMBOLS;
  localparam int TA_W  = $clog2(TDEP);

  logic [MAX_STATES-1:0] final_r, mask_r, mask_nxt, rowp_r;
  logic [NW-1:0]         ns_r, ns_val;
  logic [YNW-1:0]        nsym_r, nsym_val;
  logic [SW-1:0]         p_r, q_r, i_r;
  logic [YW-1:0]         s_r;
  logic [TA_W-1:0]       sw_r;
  logic [5:0]            ta_r, tb_r;
  logic                  cand_r, chg_r;
  logic                  out_strobe_r;
  dsd_out_t              out_item_r;

  logic                  src_ok, sym_ok;
  logic                  t_we;
  logic [TA_W-1:0]       t_waddr, t_raddr_a, t_raddr_b;
  logic [EntryW-1:0]     t_wdata, t_rd_a, t_rd_b;
  logic                  m_we;
  logic [SW-1:0]         m_waddr, m_raddr;
  logic [MAX_STATES-1:0] m_wdata, m_rd, bit_q, bit_p, init_row;
  logic                  cand_nxt;

  assign src_ok = ({1'b0, in_item.source_state} < 7'(MAX_STATES));
  assign sym_ok = ({3'b000, in_item.symbol_index} < 7'(MAX_SYMBOLS));

  // register clamping and in-use mask
  always_comb begin
    if (cfg_wdata == 7'd0) begin
      ns_val = NW'(1);
    end else if (cfg_wdata > 7'(MAX_STATES)) begin
      ns_val = NW'(MAX_STATES);
    end else begin
      ns_val = NW'(cfg_wdata);
    end
    if (cfg_wdata[4:0] == 5'd0) begin
      nsym_val = YNW'(1);
    end else if ({2'b00, cfg_wdata[4:0]} > 7'(MAX_SYMBOLS)) begin
      nsym_val = YNW'(MAX_SYMBOLS);
    end else begin
      nsym_val = YNW'(cfg_wdata[4:0]);
    end
    for (int j = 0; j < MAX_STATES; j++) begin
      mask_nxt[j] = (NW'(j) < ns_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r   <= NW'(1);
      nsym_r <= YNW'(1);
      mask_r <= MAX_STATES'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_STATES) begin
        ns_r   <= ns_val;
        mask_r <= mask_nxt;
      end else if (cfg_index == CFG_NUM_SYMBOLS) begin
        nsym_r <= nsym_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      final_r <= '0;
    end else if (cmd.accept && in_item.opcode == OP_CLEAR) begin
      final_r <= '0;
    end else if (cmd.accept && in_item.opcode == OP_MARK && src_ok) begin
      final_r[in_item.source_state[SW-1:0]] <= 1'b1;
    end
  end

  // transition store, two copies for the two pair reads
  assign t_we      = cmd.sweep_wr ||
                     (cmd.accept && in_item.opcode == OP_LOAD && src_ok && sym_ok);
  assign t_waddr   = cmd.sweep_wr ? sw_r :
                     TA_W'(in_item.source_state) * TA_W'(MAX_SYMBOLS)
                     + TA_W'(in_item.symbol_index);
  assign t_wdata   = cmd.sweep_wr ? '0 : {1'b1, in_item.target_state};
  assign t_raddr_a = TA_W'(p_r) * TA_W'(MAX_SYMBOLS) + TA_W'(s_r);
  assign t_raddr_b = TA_W'(q_r) * TA_W'(MAX_SYMBOLS) + TA_W'(s_r);

  dsd_ram #(.WIDTH(EntryW), .DEPTH(TDEP)) u_trans_a (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr_a), .rdata_r(t_rd_a)
  );

  dsd_ram #(.WIDTH(EntryW), .DEPTH(TDEP)) u_trans_b (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr_b), .rdata_r(t_rd_b)
  );

  // distinguishability matrix
  assign bit_q    = MAX_STATES'(1) << q_r;
  assign bit_p    = MAX_STATES'(1) << p_r;
  assign init_row = (final_r ^ {MAX_STATES{final_r[i_r]}}) & mask_r;

  always_comb begin
    m_we    = 1'b0;
    m_waddr = i_r;
    m_wdata = init_row;
    priority if (cmd.init_wr) begin
      m_we = 1'b1;
    end else if (cmd.wr_p) begin
      m_we    = 1'b1;
      m_waddr = p_r;
      m_wdata = rowp_r | bit_q;
    end else if (cmd.wr_q) begin
      m_we    = 1'b1;
      m_waddr = q_r;
      m_wdata = m_rd | bit_p;
    end else begin
      m_we = 1'b0;
    end
    priority if (cmd.rowp_rd) begin
      m_raddr = p_r;
    end else if (cmd.eval) begin
      m_raddr = t_rd_a[SW-1:0];
    end else if (cmd.wr_p) begin
      m_raddr = q_r;
    end else if (cmd.em_rd) begin
      m_raddr = i_r;
    end else begin
      m_raddr = i_r;
    end
  end

  dsd_ram #(.WIDTH(MAX_STATES), .DEPTH(MAX_STATES)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata_r(m_rd)
  );

  assign cand_nxt = t_rd_a[6] && t_rd_b[6] && (t_rd_a[5:0] != t_rd_b[5:0]) &&
                    ({1'b0, t_rd_a[5:0]} < 7'(ns_r)) &&
                    ({1'b0, t_rd_b[5:0]} < 7'(ns_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r         <= '0;
      i_r          <= '0;
      p_r          <= '0;
      q_r          <= '0;
      s_r          <= '0;
      chg_r        <= 1'b0;
      cand_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.accept && in_item.opcode == OP_CLEAR) begin
        sw_r <= '0;
      end else if (cmd.sweep_wr) begin
        sw_r <= sw_r + TA_W'(1);
      end
      if (cmd.i_rst) begin
        i_r <= '0;
      end else if (cmd.init_wr || cmd.em_out) begin
        i_r <= i_r + SW'(1);
      end
      if (cmd.p_set1) begin
        p_r <= SW'(1);
      end else if (cmd.p_inc) begin
        p_r <= p_r + SW'(1);
      end
      if (cmd.rowp_rd) begin
        q_r <= '0;
      end else if (cmd.q_inc) begin
        q_r <= q_r + SW'(1);
      end
      if (cmd.s_rst) begin
        s_r <= '0;
      end else if (cmd.s_inc) begin
        s_r <= s_r + YW'(1);
      end
      if (cmd.chg_clr) begin
        chg_r <= 1'b0;
      end else if (cmd.wr_p) begin
        chg_r <= 1'b1;
      end
      if (cmd.eval) begin
        cand_r <= cand_nxt;
      end
      out_strobe_r <= cmd.em_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rowp_ld) begin
      rowp_r <= m_rd;
    end else if (cmd.wr_p) begin
      rowp_r <= rowp_r | bit_q;
    end
    if (cmd.eval) begin
      ta_r <= t_rd_a[5:0];
      tb_r <= t_rd_b[5:0];
    end
    if (cmd.em_out) begin
      out_item_r.row_index <= 6'(i_r);
      out_item_r.row_bits  <= 64'(m_rd & mask_r);
      out_item_r.last_row  <= sts.i_last;
    end
  end

  assign sts.sweep_last = (sw_r == TA_W'(TDEP - 1));
  assign sts.i_last     = ((NW'(i_r) + NW'(1)) == ns_r);
  assign sts.n_one      = (ns_r == NW'(1));
  assign sts.p_last     = ((NW'(p_r) + NW'(1)) == ns_r);
  assign sts.q_eq_p     = (q_r == p_r);
  assign sts.rowp_q     = rowp_r[q_r];
  assign sts.s_last     = ((YNW'(s_r) + YNW'(1)) == nsym_r);
  assign sts.hit        = cand_r && m_rd[tb_r[SW-1:0]];
  assign sts.changed    = chg_r;

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// File: rtl/core/dfa_state_distinguish_table_top.sv
// top level: dfa state distinguishability table filling
// mark and load are accepted in idle and leave the block idle; clear sweeps the transition store
// run: initial marking of each row, then passes over the pairs, trying each symbol on an
//   unmarked pair and marking new pairs, until a pass marks nothing; then the rows are output
// one row per out_strobe, the last in the same cycle as busy drops; the receiver cannot stall
// reset: synchronous rst_n clears control state and starts the same sweep, busy meanwhile
module dfa_state_distinguish_table_top
  import dsd_pkg::*;
#(
  parameter int MAX_STATES  = MaxStatesDef,
  parameter int MAX_SYMBOLS = MaxSymbolsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dsd_in_t    in_item,
  output logic       out_strobe,
  output dsd_out_t   out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  `include "assert_macros.svh"

  dsd_cmd_t cmd;
  dsd_sts_t sts;

  dsd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .opcode(in_item.opcode),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  dsd_dp #(.MAX_STATES(MAX_STATES), .MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_item(out_item)
  );

  `DSD_ASSERT(a_row_in_run, out_strobe |-> $past(busy), "row output outside a run")
  `DSD_ASSERT(a_last_ends, (out_strobe && out_item.last_row) |=> !out_strobe, "row after last row")
  `DSD_ASSERT(a_run_busy, (start && !busy && in_item.opcode == OP_RUN) |=> busy, "run not started")

endmodule
